FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/nns_pkg.sv
package nns_pkg;

    localparam int CoordW = 32;
    localparam int IdxW   = 10;
    localparam int SteerW = 31;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StEmpty = 2'd2;

    localparam logic ActInsert = 1'b0;
    localparam logic ActQuery  = 1'b1;

    typedef struct packed {
        logic              action;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         node_idx;
        logic [31:0]        nn_distance;
        logic signed [31:0] steered_x;
        logic signed [31:0] steered_y;
        logic signed [31:0] steered_z;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_SQRT,
        S_DIV_X,
        S_DIV_Y,
        S_DIV_Z,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input word
        logic do_insert;
        logic scan_issue;  // issue one read address
        logic fetch_best;  // read best node back
        logic sqrt_start;
        logic div_start;
        logic [1:0] div_sel;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic empty;
        logic full;
        logic scan_last;   // last address issued
        logic pipe_empty;  // all compare stages drained
        logic need_steer;
        logic sqrt_done;
        logic div_done;
    } t_status;

endpackage

FILE: hw/rtl/nns_ctrl.sv
`include "assert_macros.svh"

module nns_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  nns_pkg::t_status  i_stat,
    output nns_pkg::t_cmd     o_cmd
);
    import nns_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_INSERT;
            S_INSERT: begin
                if (!i_stat.is_query || i_stat.empty) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN:   if (i_stat.scan_last) n_state = S_DRAIN;
            S_DRAIN:  if (i_stat.pipe_empty) n_state = S_FETCH;
            S_FETCH:  n_state = S_SQRT;
            S_SQRT:   begin
                if (i_stat.sqrt_done) n_state = i_stat.need_steer ? S_DIV_X : S_DONE;
            end
            S_DIV_X:  if (i_stat.div_done) n_state = S_DIV_Y;
            S_DIV_Y:  if (i_stat.div_done) n_state = S_DIV_Z;
            S_DIV_Z:  if (i_stat.div_done) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // first state after IDLE decodes the word and performs an insert; the word is loaded on accept
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_INSERT: o_cmd.do_insert = !i_stat.is_query;
            S_SCAN:   o_cmd.scan_issue = 1'b1;
            S_DRAIN:  ;
            S_FETCH:  begin
                o_cmd.fetch_best = 1'b1;
                o_cmd.sqrt_start = 1'b1;
            end
            S_SQRT:   begin
                o_cmd.div_start  = i_stat.sqrt_done && i_stat.need_steer;
                o_cmd.div_sel    = 2'd0;
            end
            S_DIV_X: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_sel   = i_stat.div_done ? 2'd1 : 2'd0;
            end
            S_DIV_Y: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_sel   = i_stat.div_done ? 2'd2 : 2'd1;
            end
            S_DIV_Z:  o_cmd.div_sel = 2'd2;
            S_DONE:   o_cmd.emit = 1'b1;
            default:  ;
        endcase
    end

    `ASSERT_CLK(a_emit_once, i_clk, i_rst_n, o_cmd.emit |=> !o_cmd.emit, "double emit")
    `ASSERT_CLK(a_load_idle, i_clk, i_rst_n, o_cmd.load |-> (r_state == S_IDLE), "load busy")
    `ASSERT_CLK(a_emit_after, i_clk, i_rst_n, o_cmd.emit |=> !busy, "no idle after emit")

endmodule

FILE: hw/rtl/nns_dp.sv
`include "assert_macros.svh"

module nns_dp #(
    parameter int MAX_NODES = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nns_pkg::t_in_word i_word,
    input  logic              i_cfg_we,
    input  logic [30:0]       i_cfg_data,
    input  nns_pkg::t_cmd     i_cmd,
    output nns_pkg::t_status  o_stat,
    output logic              o_valid,
    output nns_pkg::t_out_word o_word
);
    import nns_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [30:0]   r_steer;
    logic [CW-1:0] r_count;
    t_in_word      r_in;

    logic [31:0] mem_x [MAX_NODES];
    logic [31:0] mem_y [MAX_NODES];
    logic [31:0] mem_z [MAX_NODES];

    logic [AW-1:0] r_addr;
    logic [AW-1:0] mem_addr;
    logic [31:0]   r_rx, r_ry, r_rz;

    // scan pipeline: read (1) -> diff (2) -> square (3) -> sum (4) -> compare
    logic [3:0]    r_vld;
    logic [AW-1:0] r_i1, r_i2, r_i3, r_i4;
    logic [32:0]   r_dx, r_dy, r_dz;
    logic [65:0]   r_qx, r_qy, r_qz;
    logic [67:0]   r_sum;
    logic [67:0]   r_best_s;
    logic [AW-1:0] r_best;
    logic          r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer <= 31'(1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            r_steer <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.do_insert && r_count != CW'(MAX_NODES)) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign mem_addr = i_cmd.fetch_best ? r_best : r_addr;

    // write inserted nodes; read on scan or fetch and hold the read word once the best node has been fetched
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert && r_count != CW'(MAX_NODES)) begin
            mem_x[r_count[AW-1:0]] <= r_in.coord_x;
            mem_y[r_count[AW-1:0]] <= r_in.coord_y;
            mem_z[r_count[AW-1:0]] <= r_in.coord_z;
        end
        if (i_cmd.scan_issue || i_cmd.fetch_best) begin
            r_rx <= mem_x[mem_addr];
            r_ry <= mem_y[mem_addr];
            r_rz <= mem_z[mem_addr];
        end
    end

    logic scan_last;
    assign scan_last = ({1'b0, r_addr} == CW'(r_count - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_vld  <= '0;
        end else begin
            if (i_cmd.load) r_addr <= '0;
            else if (i_cmd.scan_issue) r_addr <= r_addr + 1'b1;
            r_vld <= {r_vld[2:0], i_cmd.scan_issue};
        end
    end

    logic [32:0] d_x, d_y, d_z;
    always_comb begin
        d_x = 33'($signed(r_in.coord_x)) - 33'($signed(r_rx));
        d_y = 33'($signed(r_in.coord_y)) - 33'($signed(r_ry));
        d_z = 33'($signed(r_in.coord_z)) - 33'($signed(r_rz));
    end

    function automatic logic [32:0] mag33(input logic [32:0] v);
        mag33 = v[32] ? (~v + 1'b1) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        r_i1 <= r_addr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_dx <= mag33(d_x);
        r_dy <= mag33(d_y);
        r_dz <= mag33(d_z);
        r_qx <= r_dx * r_dx;
        r_qy <= r_dy * r_dy;
        r_qz <= r_dz * r_dz;
        r_sum <= 68'(r_qx) + 68'(r_qy) + 68'(r_qz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.load) begin
            r_have <= 1'b0;
        end else if (r_vld[3]) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[3] && (!r_have || r_sum < r_best_s)) begin
            r_best_s <= r_sum;
            r_best   <= r_i4;
        end
    end

    // fetch_best: read back node; r_rx.. hold it from the next cycle on
    logic [61:0] lim;
    logic        r_steer_need;
    always_ff @(posedge i_clk) begin
        r_steer_need <= ({6'd0, lim} < r_best_s);
    end
    assign lim = r_steer * r_steer;

    // bit-serial square root, two radicand bits a cycle, one root bit out
    logic [36:0] r_root;
    logic [67:0] r_sq_rad;
    logic [34:0] r_sq_rem;
    logic [5:0]  r_sq_cnt;
    logic        r_sq_busy, r_sq_done;
    logic [36:0] sq_acc, sq_trial, sq_diff;
    assign sq_acc   = {r_sq_rem, r_sq_rad[67:66]};
    assign sq_trial = {1'b0, r_root[33:0], 2'b01};
    assign sq_diff  = sq_acc - sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= r_sq_busy && (r_sq_cnt == 6'd1);
            if (i_cmd.sqrt_start) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= 6'd34;
                r_sq_rad  <= r_best_s;
                r_sq_rem  <= '0;
                r_root    <= '0;
            end else if (r_sq_busy) begin
                r_sq_rad <= {r_sq_rad[65:0], 2'b00};
                if (sq_acc >= sq_trial) begin
                    r_sq_rem <= sq_diff[34:0];
                    r_root   <= {r_root[35:0], 1'b1};
                end else begin
                    r_sq_rem <= sq_acc[34:0];
                    r_root   <= {r_root[35:0], 1'b0};
                end
                if (r_sq_cnt == 6'd1) r_sq_busy <= 1'b0;
                r_sq_cnt <= r_sq_cnt - 1'b1;
            end
        end
    end

    // restoring divider: (|d|*steer + r/2) / r, 64-bit numerator
    logic [32:0]  sel_d;
    logic         sel_neg;
    logic [31:0]  sel_node;
    logic [36:0]  rr;
    assign rr = (r_root == '0) ? 37'd1 : r_root;

    always_comb begin
        unique case (i_cmd.div_sel)
            2'd0: begin
                sel_d = 33'($signed(r_in.coord_x)) - 33'($signed(r_rx));
                sel_node = r_rx;
            end
            2'd1: begin
                sel_d = 33'($signed(r_in.coord_y)) - 33'($signed(r_ry));
                sel_node = r_ry;
            end
            default: begin
                sel_d = 33'($signed(r_in.coord_z)) - 33'($signed(r_rz));
                sel_node = r_rz;
            end
        endcase
        sel_neg = sel_d[32];
    end

    logic [63:0] r_prod;
    logic [63:0] r_num;
    logic [37:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_dcnt;
    logic [1:0]  r_dphase;
    logic        r_div_done, r_dneg;
    logic [31:0] r_dnode;
    logic [1:0]  r_dsel;
    logic [37:0] rem_sh;
    assign rem_sh = {r_rem[36:0], r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dphase   <= '0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= (r_dphase == 2'd3);
            unique case (r_dphase)
                2'd0: if (i_cmd.div_start) begin
                    r_prod   <= 64'(mag33(sel_d)) * 64'(r_steer);
                    r_dneg   <= sel_neg;
                    r_dnode  <= sel_node;
                    r_dsel   <= i_cmd.div_sel;
                    r_dphase <= 2'd1;
                end
                2'd1: begin
                    r_num    <= r_prod + 64'(rr >> 1);
                    r_rem    <= '0;
                    r_quo    <= '0;
                    r_dcnt   <= 7'd64;
                    r_dphase <= 2'd2;
                end
                2'd2: begin
                    r_num <= {r_num[62:0], 1'b0};
                    if (rem_sh >= {1'b0, rr}) begin
                        r_rem <= rem_sh - {1'b0, rr};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == 7'd1) r_dphase <= 2'd3;
                end
                default: begin
                    r_dphase   <= 2'd0;
                end
            endcase
        end
    end

    // node +/- quotient, saturated
    logic [65:0] sres;
    logic [31:0] sat_v;
    always_comb begin
        sres = r_dneg ? 66'($signed(r_dnode)) - {2'b0, r_quo}
                      : 66'($signed(r_dnode)) + {2'b0, r_quo};
        if ($signed(sres) > 66'sh7FFFFFFF) sat_v = 32'h7FFFFFFF;
        else if ($signed(sres) < -66'sh80000000) sat_v = 32'h80000000;
        else sat_v = sres[31:0];
    end

    logic [31:0] r_sx, r_sy, r_sz;
    always_ff @(posedge i_clk) begin
        if (r_div_done) begin
            unique case (r_dsel)
                2'd0:    r_sx <= sat_v;
                2'd1:    r_sy <= sat_v;
                default: r_sz <= sat_v;
            endcase
        end
    end

    // full flag latched when an insert is refused
    logic r_full_hit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_full_hit <= 1'b0;
        end else if (i_cmd.do_insert && r_count == CW'(MAX_NODES)) begin
            r_full_hit <= 1'b1;
        end
    end

    // result word
    t_out_word res_word;
    always_comb begin
        res_word = '0;
        if (r_in.action == ActInsert) begin
            if (r_full_hit) res_word.status = StFull;
            else res_word.node_idx = 10'(r_count - 1'b1);
        end else if (r_count == '0) begin
            res_word.status = StEmpty;
        end else begin
            res_word.node_idx = 10'(r_best);
            if (r_steer_need) begin
                res_word.nn_distance = {1'b0, r_steer};
                res_word.steered_x   = r_sx;
                res_word.steered_y   = r_sy;
                res_word.steered_z   = r_sz;
            end else begin
                res_word.nn_distance = (r_root[36:32] != '0) ? 32'hFFFFFFFF
                                                             : r_root[31:0];
                res_word.steered_x   = r_in.coord_x;
                res_word.steered_y   = r_in.coord_y;
                res_word.steered_z   = r_in.coord_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) o_word <= res_word;
    end

    always_comb begin
        o_stat            = '0;
        o_stat.is_query   = (r_in.action == ActQuery);
        o_stat.empty      = (r_count == '0);
        o_stat.full       = r_full_hit;
        o_stat.scan_last  = scan_last;
        o_stat.pipe_empty = (r_vld == '0);
        o_stat.need_steer = r_steer_need;
        o_stat.sqrt_done  = r_sq_done;
        o_stat.div_done   = r_div_done;
    end

    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_NODES), "count over")
    `ASSERT_CLK(a_div_idle, i_clk, i_rst_n, i_cmd.div_start |-> (r_dphase == 2'd0), "div busy")
    `ASSERT_CLK(a_sqrt_idle, i_clk, i_rst_n, i_cmd.sqrt_start |-> !r_sq_busy, "sqrt busy")

endmodule

FILE: hw/rtl/nearest_node_search_and_steer_unit.sv
// Nearest-node search and steer. Raise start with the word while busy is low;
// the result appears for one cycle with o_valid and cannot be stalled, so it
// must be captured then. o_valid rises in the cycle in which busy falls. An
// insert, or a query on an empty table, keeps busy high through the insert
// state and the emit state. A query over N stored nodes keeps busy high through
// the insert state, the scan reading one node a cycle from the position memory,
// the compare pipeline drain, the read-back of the nearest node, the bit-serial
// square root and the emit state. Steering adds three restoring divisions. The
// user must write configuration only while idle; the block does not enforce it.
module nearest_node_search_and_steer_unit #(
    parameter int MAX_NODES = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  nns_pkg::t_in_word  i_word,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    output nns_pkg::t_out_word o_word
);
    import nns_pkg::*;

    t_cmd    cmd;
    t_status stat;
    logic    start_acc;

    assign start_acc = start;

    nns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start_acc),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    nns_dp #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_word     (o_word)
    );

endmodule

FILE: sim/tb_nearest_node_search_and_steer_unit.sv
`timescale 1ns / 100ps

module tb_nearest_node_search_and_steer_unit;
    import nns_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam logic [30:0] STEER_RESET = 31'd65536;
    localparam logic [30:0] STEER_MAX   = 31'h7FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    word_in = '0;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_data = '0;
    logic        o_valid;
    t_out_word   word_out;

    // shadow of the node table and the steer register
    logic signed [31:0] node_x [TABLE_DEPTH];
    logic signed [31:0] node_y [TABLE_DEPTH];
    logic signed [31:0] node_z [TABLE_DEPTH];
    int unsigned        node_count = 0;
    logic [30:0]        steer_len = STEER_RESET;

    t_in_word  pending_words [$];
    t_out_word awaited_words [$];
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned errors = 0;

    // planned node positions, used to aim queries close to stored nodes
    logic signed [31:0] plan_x [$];
    logic signed [31:0] plan_y [$];
    logic signed [31:0] plan_z [$];

    nearest_node_search_and_steer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (word_in),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_valid    (o_valid),
        .o_word     (word_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 36; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] steer_toward(longint nd, longint d,
                                                       logic [127:0] r);
        logic [127:0] m;
        logic [127:0] q;
        longint v;
        m = (d < 0) ? 128'(-d) : 128'(d);
        q = (m * steer_len + (r >> 1)) / r;
        v = (d < 0) ? nd - longint'(q) : nd + longint'(q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // works out the result of one word and updates the shadow table
    function automatic t_out_word search_and_steer(t_in_word w);
        t_out_word res;
        logic [127:0] best_sq;
        logic [127:0] sq;
        logic [127:0] r;
        longint dx, dy, dz, nx, ny, nz;
        int unsigned best;
        res = '0;
        best = 0;
        best_sq = '0;
        if (w.action == ActInsert) begin
            if (node_count >= TABLE_DEPTH) begin
                res.status = StFull;
            end else begin
                node_x[node_count] = w.coord_x;
                node_y[node_count] = w.coord_y;
                node_z[node_count] = w.coord_z;
                res.node_idx = node_count[9:0];
                node_count++;
            end
            return res;
        end
        if (node_count == 0) begin
            res.status = StEmpty;
            return res;
        end
        for (int unsigned i = 0; i < node_count; i++) begin
            dx = longint'(w.coord_x) - longint'(node_x[i]);
            dy = longint'(w.coord_y) - longint'(node_y[i]);
            dz = longint'(w.coord_z) - longint'(node_z[i]);
            sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
            if (i == 0 || sq < best_sq) begin
                best_sq = sq;
                best = i;
            end
        end
        res.node_idx = best[9:0];
        r = isqrt(best_sq);
        if (best_sq > 128'(steer_len) * 128'(steer_len)) begin
            nx = node_x[best];
            ny = node_y[best];
            nz = node_z[best];
            res.nn_distance = 32'(steer_len);
            res.steered_x = steer_toward(nx, longint'(w.coord_x) - nx, r);
            res.steered_y = steer_toward(ny, longint'(w.coord_y) - ny, r);
            res.steered_z = steer_toward(nz, longint'(w.coord_z) - nz, r);
        end else begin
            res.nn_distance = (r > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
            res.steered_x = w.coord_x;
            res.steered_y = w.coord_y;
            res.steered_z = w.coord_z;
        end
        return res;
    endfunction

    // driver: bursts of words with random gaps in between
    always @(posedge i_clk) begin
        t_in_word nxt_word;
        logic     nxt_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_word  = word_in;
            if (start && !busy) begin
                awaited_words = {awaited_words, search_and_steer(word_in)};
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    nxt_word  = pending_words.pop_front();
                    nxt_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
            end
            start   <= nxt_start;
            word_in <= nxt_word;
        end
    end

    // monitor: results cannot be held off, so check every strobe
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid) begin
            if (awaited_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, word_out);
                errors++;
            end else begin
                exp_w = awaited_words.pop_front();
                if (word_out.status !== exp_w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_w.status, word_out.status);
                    errors++;
                end
                if (word_out.node_idx !== exp_w.node_idx) begin
                    $display("%0t: node_idx expected %0d actual %0d",
                             $time, exp_w.node_idx, word_out.node_idx);
                    errors++;
                end
                if (word_out.nn_distance !== exp_w.nn_distance) begin
                    $display("%0t: nn_distance expected %h actual %h",
                             $time, exp_w.nn_distance, word_out.nn_distance);
                    errors++;
                end
                if (word_out.steered_x !== exp_w.steered_x) begin
                    $display("%0t: steered_x expected %h actual %h",
                             $time, exp_w.steered_x, word_out.steered_x);
                    errors++;
                end
                if (word_out.steered_y !== exp_w.steered_y) begin
                    $display("%0t: steered_y expected %h actual %h",
                             $time, exp_w.steered_y, word_out.steered_y);
                    errors++;
                end
                if (word_out.steered_z !== exp_w.steered_z) begin
                    $display("%0t: steered_z expected %h actual %h",
                             $time, exp_w.steered_z, word_out.steered_z);
                    errors++;
                end
            end
        end
    end

    task automatic push_word(logic act, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        t_in_word w;
        w.action  = act;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        pending_words = {pending_words, w};
        if (act == ActInsert) begin
            plan_x = {plan_x, x};
            plan_y = {plan_y, y};
            plan_z = {plan_z, z};
        end
    endtask

    // hold the sender until every expected word has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || awaited_words.size() != 0 || start || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_steer(logic [30:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        steer_len = v;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2:       return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
                                                 : 32'sh8000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    task automatic push_query();
        int unsigned k;
        int unsigned span;
        if (plan_x.size() > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, (plan_x.size() > TABLE_DEPTH ? TABLE_DEPTH
                                                               : plan_x.size()) - 1);
            span = 1 << $urandom_range(0, 20);
            push_word(ActQuery,
                      plan_x[k] + $signed($urandom_range(0, 2 * span)) - $signed(span),
                      plan_y[k] + $signed($urandom_range(0, 2 * span)) - $signed(span),
                      plan_z[k] + $signed($urandom_range(0, 2 * span)) - $signed(span));
        end else begin
            push_word(ActQuery, rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic push_random_chunk(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 45)
                push_word(ActInsert, rand_coord(), rand_coord(), rand_coord());
            else
                push_query();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, exact distance, steering, ties
        push_word(ActQuery, 32'sd0, 32'sd0, 32'sd0);
        push_word(ActInsert, 32'sd0, 32'sd0, 32'sd0);
        push_word(ActInsert, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_word(ActInsert, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_word(ActInsert, 32'sd0, 32'sd0, 32'sd0);
        push_word(ActQuery, 32'sd0, 32'sd0, 32'sd0);
        push_word(ActQuery, 32'sd65536, 32'sd0, 32'sd0);
        push_word(ActQuery, 32'sd196608, 32'sd262144, 32'sd0);
        push_word(ActQuery, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_word(ActQuery, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_word(ActInsert, 32'sd1000000, 32'sd5, 32'sd5);
        push_word(ActInsert, 32'sd1000000, -32'sd5, 32'sd5);
        push_word(ActQuery, 32'sd1000000, 32'sd0, 32'sd5);
        push_word(ActQuery, 32'sd1000000, 32'sd0, -32'sd7);
        write_steer(31'd0);
        push_word(ActQuery, 32'sd1000, -32'sd2000, 32'sd3);
        push_word(ActQuery, 32'sd0, 32'sd0, 32'sd0);
        write_steer(STEER_MAX);
        push_word(ActQuery, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_word(ActQuery, 32'sh4000_0000, -32'sh4000_0000, 32'sd12345);
        write_steer(31'd1);
        push_word(ActQuery, 32'sd3, 32'sd4, 32'sd0);
        push_word(ActQuery, -32'sd1, -32'sd1, -32'sd1);

        // random, across several steer lengths
        write_steer(31'($urandom));
        push_random_chunk(130);
        write_steer(STEER_MAX);
        push_random_chunk(130);
        write_steer(31'($urandom_range(0, 32'h0004_0000)));
        push_random_chunk(130);
        write_steer(STEER_RESET);
        push_random_chunk(130);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("** nearest_node_search_and_steer_unit: PASSED **");
        else
            $display("** nearest_node_search_and_steer_unit: FAILED **");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** nearest_node_search_and_steer_unit: FAILED **");
        $finish;
    end

endmodule
